// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the correlation meter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assertion on the block clock and reset.
`define ASSERT_DEFAULT(label, prop, msg) \
  `ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// File: sv/spcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo phase correlation meter package
// Types, widths and constants shared by the meter's modules.
// ----------------------------------------------------------------------------
package spcm_pkg;

  // Sample and result widths.
  localparam int SAMPLE_BITS      = 24;
  localparam int WINDOW_DEPTH_DEF = 1024;
  localparam int CORR_W           = 16;
  localparam int WEIGHT_W         = 16;
  localparam int THRESH_W         = 32;
  localparam int QUO_BITS         = 16;
  localparam int CFG_INDEX_W      = 4;
  localparam int CFG_DATA_W       = 32;

  // Running sums hold the exact window totals, capped at 64 bits.
  localparam int SUM_W_DEF = (2 * SAMPLE_BITS + $clog2(WINDOW_DEPTH_DEF) > 64) ? 64 :
                             2 * SAMPLE_BITS + $clog2(WINDOW_DEPTH_DEF);

  // Shared multiplier operand width: samples, or a 17-bit smoothing term.
  localparam int MUL_OP_W = (SAMPLE_BITS > WEIGHT_W + 1) ? SAMPLE_BITS : WEIGHT_W + 1;

  // Correlation limits in Q1.15.
  localparam logic signed [CORR_W-1:0] CORR_MAX = 16'sd32767;
  localparam logic signed [CORR_W-1:0] CORR_MIN = -16'sd32767;

  // Configuration register indexes and reset values.
  localparam logic [CFG_INDEX_W-1:0] CFG_SILENCE_THRESHOLD = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SMOOTHING_WEIGHT  = 4'd1;
  localparam logic [THRESH_W-1:0]    THRESH_RESET          = 32'd7037;
  localparam logic [WEIGHT_W-1:0]    WEIGHT_RESET          = 16'd9830;

  // Input item kinds.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  typedef struct packed {
    logic                          kind;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [CORR_W-1:0] raw_correlation;
    logic signed [CORR_W-1:0] smoothed_correlation;
    logic                     silent;
  } out_item_t;

  // Status handed from the correlation unit to the sequencer.
  typedef struct packed {
    logic                     done;
    logic                     silent;
    logic signed [CORR_W-1:0] raw;
  } calc_res_t;

  // Top-level sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SAMPLE,
    ST_CALC,
    ST_SMOOTH_MUL,
    ST_SMOOTH_OUT
  } spcm_state_e;

  // Steps of a sample transfer: each but the last forms one product, accumulated in the next step.
  typedef enum logic [2:0] {
    STEP_LR,
    STEP_OLR,
    STEP_LL,
    STEP_OLL,
    STEP_RR,
    STEP_ORR,
    STEP_DONE
  } smp_step_e;

  // Correlation unit states.
  typedef enum logic [2:0] {
    C_IDLE,
    C_MUL,
    C_SQRT,
    C_CHECK,
    C_DIV,
    C_ROUND,
    C_DONE
  } calc_state_e;

endpackage

// File: sv/spcm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with a registered read.
// ----------------------------------------------------------------------------
module spcm_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/spcm_calc.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// Correlation unit
// Forms sumLR / sqrt(sumLL * sumRR) in Q1.15 with one bit-serial datapath:
// shift-add product, restoring square root, restoring division.
// ----------------------------------------------------------------------------
module spcm_calc #(
  parameter int SUM_W = spcm_pkg::SUM_W_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [SUM_W-1:0]              sum_cross_i,
  input  logic [SUM_W-1:0]              sum_left_i,
  input  logic [SUM_W-1:0]              sum_right_i,
  input  logic [spcm_pkg::THRESH_W-1:0] threshold_i,
  output spcm_pkg::calc_res_t           res_o
);

  import spcm_pkg::*;

  localparam int PROD_W = 2 * SUM_W;
  localparam int REM_W  = SUM_W + 3;
  localparam int CNT_W  = $clog2(SUM_W);
  localparam int CMP_W  = (SUM_W > THRESH_W) ? SUM_W : THRESH_W;

  calc_state_e state_q, state_d;
  logic [PROD_W-1:0]        p_q, p_d;
  logic [SUM_W-1:0]         mr_q, mr_d;
  logic [REM_W-1:0]         rem_q, rem_d;
  logic [SUM_W-1:0]         root_q, root_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [QUO_BITS-1:0]      q_q, q_d;
  logic signed [CORR_W-1:0] raw_q, raw_d;
  logic                     silent_q, silent_d;

  logic                     cross_neg;
  logic [SUM_W-1:0]         cross_mag;
  logic [PROD_W-1:0]        mul_sum;
  logic [REM_W-1:0]         sq_rem_sh;
  logic [REM_W-1:0]         sq_trial;
  logic                     sq_fit;
  logic [SUM_W:0]           div_t;
  logic                     div_fit;
  logic                     is_silent;
  logic                     cnt_last;
  logic [QUO_BITS:0]        round_sum;
  logic [QUO_BITS-1:0]      round_mag;
  logic signed [CORR_W-1:0] sat_mag;

  // Sign and magnitude of the cross sum.
  assign cross_neg = sum_cross_i[SUM_W-1];
  assign cross_mag = cross_neg ? (SUM_W'(0) - sum_cross_i) : sum_cross_i;

  // Shift-add multiply step, most significant multiplier bit first.
  assign mul_sum = {p_q[PROD_W-2:0], 1'b0} + (mr_q[SUM_W-1] ? PROD_W'(sum_left_i) : '0);

  // Restoring square root step on the next two radicand bits.
  assign sq_rem_sh = {rem_q[REM_W-3:0], p_q[PROD_W-1 -: 2]};
  assign sq_trial  = REM_W'({root_q, 2'b01});
  assign sq_fit    = (sq_rem_sh >= sq_trial);

  // Restoring division step: double the remainder and try the denominator.
  assign div_t   = {rem_q[SUM_W-1:0], 1'b0};
  assign div_fit = (div_t >= {1'b0, root_q});

  assign is_silent = (root_q == '0) || (CMP_W'(root_q) < CMP_W'(threshold_i));
  assign cnt_last  = (cnt_q == '0);

  // Round the 16-bit quotient to 15 fraction bits, halves up, and saturate.
  assign round_sum = (QUO_BITS + 1)'(q_q) + 1'b1;
  assign round_mag = round_sum[QUO_BITS:1];
  assign sat_mag   = (round_mag > $unsigned(CORR_MAX)) ? CORR_MAX : $signed(round_mag);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      C_IDLE: begin
        if (start_i) begin
          state_d = C_MUL;
        end
      end
      C_MUL: begin
        if (cnt_last) begin
          state_d = C_SQRT;
        end
      end
      C_SQRT: begin
        if (cnt_last) begin
          state_d = C_CHECK;
        end
      end
      C_CHECK: begin
        if (is_silent || (cross_mag >= root_q)) begin
          state_d = C_DONE;
        end else begin
          state_d = C_DIV;
        end
      end
      C_DIV: begin
        if (cnt_last) begin
          state_d = C_ROUND;
        end
      end
      C_ROUND: state_d = C_DONE;
      C_DONE:  state_d = C_IDLE;
      default: state_d = C_IDLE;
    endcase
  end

  // Datapath updates for each state.
  always_comb begin
    p_d      = p_q;
    mr_d     = mr_q;
    rem_d    = rem_q;
    root_d   = root_q;
    cnt_d    = cnt_q;
    q_d      = q_q;
    raw_d    = raw_q;
    silent_d = silent_q;
    case (state_q)
      C_IDLE: begin
        if (start_i) begin
          p_d   = '0;
          mr_d  = sum_right_i;
          cnt_d = CNT_W'(SUM_W - 1);
        end
      end
      C_MUL: begin
        p_d  = mul_sum;
        mr_d = {mr_q[SUM_W-2:0], 1'b0};
        if (cnt_last) begin
          cnt_d  = CNT_W'(SUM_W - 1);
          rem_d  = '0;
          root_d = '0;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      C_SQRT: begin
        p_d    = {p_q[PROD_W-3:0], 2'b00};
        rem_d  = sq_fit ? (sq_rem_sh - sq_trial) : sq_rem_sh;
        root_d = {root_q[SUM_W-2:0], sq_fit};
        cnt_d  = cnt_q - 1'b1;
      end
      C_CHECK: begin
        if (is_silent) begin
          raw_d    = '0;
          silent_d = 1'b1;
        end else if (cross_mag >= root_q) begin
          raw_d    = cross_neg ? CORR_MIN : CORR_MAX;
          silent_d = 1'b0;
        end else begin
          rem_d = REM_W'(cross_mag);
          q_d   = '0;
          cnt_d = CNT_W'(QUO_BITS - 1);
        end
      end
      C_DIV: begin
        rem_d = div_fit ? REM_W'(div_t - {1'b0, root_q}) : REM_W'(div_t);
        q_d   = {q_q[QUO_BITS-2:0], div_fit};
        cnt_d = cnt_q - 1'b1;
      end
      C_ROUND: begin
        raw_d    = cross_neg ? -sat_mag : sat_mag;
        silent_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    p_q      <= p_d;
    mr_q     <= mr_d;
    rem_q    <= rem_d;
    root_q   <= root_d;
    q_q      <= q_d;
    raw_q    <= raw_d;
    silent_q <= silent_d;
  end

  assign res_o.done   = (state_q == C_DONE);
  assign res_o.silent = silent_q;
  assign res_o.raw    = raw_q;

  // A silent result carries a zero correlation.
  `ASSERT_DEFAULT(a_silent_zero, res_o.done && res_o.silent |-> res_o.raw == '0, "silent nonzero")
  // The raw correlation never reaches the negative full scale.
  `ASSERT_DEFAULT(a_raw_range, res_o.done |-> res_o.raw >= CORR_MIN, "raw below range")
  // A new computation starts only from the idle state.
  `ASSERT_DEFAULT(a_start_idle, start_i |-> state_q == C_IDLE, "start while busy")

endmodule

// File: sv/stereo_phase_correlation_meter.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// Stereo phase correlation meter
// Sliding-window correlation of a stereo stream with exponential smoothing.
// ----------------------------------------------------------------------------
// A sample transfer: one signed multiplier forms the six products of the new
// and the retired sample pair in turn, and one adder folds them into the three
// window sums; no further item is accepted until the transfer ends. For an
// update that follows new samples, a bit-serial unit forms sumLL*sumRR one bit
// a cycle, then its square root two radicand bits a cycle, then the 16-bit
// quotient one bit a cycle, before the shared multiplier does the smoothing.
// The sums are 58 bits wide at the default window of 1024. When the reading is
// silent or saturates there is no quotient. An update transfer also holds the
// input while the previous result still waits in the output register. An
// update with no new samples since the last one is taken and gives no result.
// The window lives in one RAM; entries not yet written since reset read as
// zero through a fill flag, so there is no clearing pass after reset. A
// finished result waits in the output register while further samples are
// accepted; configuration writes are always ready.
module stereo_phase_correlation_meter #(
  parameter int WINDOW_DEPTH = spcm_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  spcm_pkg::in_item_t               in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output spcm_pkg::out_item_t              out_item_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [spcm_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [spcm_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  import spcm_pkg::*;

  localparam int AW       = $clog2(WINDOW_DEPTH);
  localparam int SUM_W    = (2 * SAMPLE_BITS + AW > 64) ? 64 : 2 * SAMPLE_BITS + AW;
  localparam int PRD_W    = 2 * MUL_OP_W;
  localparam int SM_ACC_W = 36;
  localparam int SM_SH_W  = SM_ACC_W - WEIGHT_W;
  localparam logic signed [SM_SH_W-1:0]  SM_HI    = SM_SH_W'(CORR_MAX);
  localparam logic signed [SM_SH_W-1:0]  SM_LO    = SM_SH_W'(CORR_MIN);
  localparam logic [SM_ACC_W-1:0]        SM_ROUND = SM_ACC_W'(1) << (WEIGHT_W - 1);

  spcm_state_e state_q, state_d;
  smp_step_e   step_q, step_d;
  logic [AW-1:0]              wptr_q, wptr_d;
  logic                       full_q, full_d;
  logic                       fresh_q, fresh_d;
  logic signed [CORR_W-1:0]   sm_q, sm_d;
  logic [THRESH_W-1:0]        thr_q, thr_d;
  logic [WEIGHT_W-1:0]        weight_q, weight_d;
  logic [SUM_W-1:0]           sum_x_q, sum_x_d;
  logic [SUM_W-1:0]           sum_l_q, sum_l_d;
  logic [SUM_W-1:0]           sum_r_q, sum_r_d;
  logic                       out_valid_q, out_valid_d;
  out_item_t                  out_q, out_d;
  logic signed [SAMPLE_BITS-1:0] smp_l_q, smp_r_q;
  logic signed [PRD_W-1:0]    prod_q, prod_d;

  logic                          in_fire;
  logic                          cfg_fire;
  logic                          calc_start;
  calc_res_t                     calc_res;
  logic [2*SAMPLE_BITS-1:0]      ram_rdata;
  logic                          ram_we;
  logic                          ram_re;
  logic signed [SAMPLE_BITS-1:0] old_l, old_r;
  logic signed [MUL_OP_W-1:0]    mul_a, mul_b;
  logic [SUM_W-1:0]              prod_ext;
  logic [SUM_W-1:0]              add_in, add_out;
  logic                          add_sub;
  logic signed [CORR_W:0]        sm_diff;
  logic signed [SM_ACC_W-1:0]    sm_acc;
  logic signed [SM_SH_W-1:0]     sm_sh;
  logic signed [CORR_W-1:0]      sm_new;
  logic                          out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign calc_start  = in_fire && (in_item_i.kind == KIND_UPDATE) && fresh_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // Window storage: left sample in the upper half, right in the lower half.
  assign ram_re = in_fire && (in_item_i.kind == KIND_SAMPLE);
  assign ram_we = (state_q == ST_SAMPLE) && (step_q == STEP_DONE);

  spcm_ram #(
    .WIDTH (2 * SAMPLE_BITS),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wptr_q),
    .wdata_i ({smp_l_q, smp_r_q}),
    .re_i    (ram_re),
    .raddr_i (wptr_q),
    .rdata_o (ram_rdata)
  );

  // Entries not yet written since reset read as zero.
  assign old_l = full_q ? $signed(ram_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS]) : '0;
  assign old_r = full_q ? $signed(ram_rdata[SAMPLE_BITS-1:0]) : '0;

  spcm_calc #(
    .SUM_W (SUM_W)
  ) u_calc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (calc_start),
    .sum_cross_i (sum_x_q),
    .sum_left_i  (sum_l_q),
    .sum_right_i (sum_r_q),
    .threshold_i (thr_q),
    .res_o       (calc_res)
  );

  // Shared multiplier operand selection.
  assign sm_diff = (CORR_W + 1)'(calc_res.raw) - (CORR_W + 1)'(sm_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SAMPLE: begin
        case (step_q)
          STEP_LR: begin
            mul_a = MUL_OP_W'(smp_l_q);
            mul_b = MUL_OP_W'(smp_r_q);
          end
          STEP_OLR: begin
            mul_a = MUL_OP_W'(old_l);
            mul_b = MUL_OP_W'(old_r);
          end
          STEP_LL: begin
            mul_a = MUL_OP_W'(smp_l_q);
            mul_b = MUL_OP_W'(smp_l_q);
          end
          STEP_OLL: begin
            mul_a = MUL_OP_W'(old_l);
            mul_b = MUL_OP_W'(old_l);
          end
          STEP_RR: begin
            mul_a = MUL_OP_W'(smp_r_q);
            mul_b = MUL_OP_W'(smp_r_q);
          end
          STEP_ORR: begin
            mul_a = MUL_OP_W'(old_r);
            mul_b = MUL_OP_W'(old_r);
          end
          default: begin
          end
        endcase
      end
      // The smoothing product is held while the result waits for the output.
      ST_SMOOTH_MUL, ST_SMOOTH_OUT: begin
        mul_a = MUL_OP_W'(sm_diff);
        mul_b = MUL_OP_W'($signed({1'b0, weight_q}));
      end
      default: begin
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Shared accumulator: the product of the previous step enters one sum.
  assign prod_ext = SUM_W'(prod_q);
  assign add_sub  = step_q inside {STEP_LL, STEP_RR, STEP_DONE};

  always_comb begin
    case (step_q)
      STEP_OLR, STEP_LL:   add_in = sum_x_q;
      STEP_OLL, STEP_RR:   add_in = sum_l_q;
      STEP_ORR, STEP_DONE: add_in = sum_r_q;
      default:             add_in = '0;
    endcase
  end

  assign add_out = add_sub ? (add_in - prod_ext) : (add_in + prod_ext);

  // Smoothing: old + (raw - old) * w, rounded half up, then saturated.
  assign sm_acc = SM_ACC_W'(prod_q) + (SM_ACC_W'(sm_q) <<< WEIGHT_W) + $signed(SM_ROUND);
  assign sm_sh  = sm_acc[SM_ACC_W-1:WEIGHT_W];
  assign sm_new = (sm_sh > SM_HI) ? CORR_MAX :
                  (sm_sh < SM_LO) ? CORR_MIN : sm_sh[CORR_W-1:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_item_i.kind == KIND_SAMPLE) begin
            state_d = ST_SAMPLE;
          end else if (fresh_q) begin
            state_d = ST_CALC;
          end
        end
      end
      ST_SAMPLE: begin
        if (step_q == STEP_DONE) begin
          state_d = ST_IDLE;
        end
      end
      ST_CALC: begin
        if (calc_res.done) begin
          state_d = ST_SMOOTH_MUL;
        end
      end
      ST_SMOOTH_MUL: state_d = ST_SMOOTH_OUT;
      ST_SMOOTH_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Register updates driven by the sequencer.
  always_comb begin
    step_d      = step_q;
    wptr_d      = wptr_q;
    full_d      = full_q;
    fresh_d     = fresh_q;
    sm_d        = sm_q;
    thr_d       = thr_q;
    weight_d    = weight_q;
    sum_x_d     = sum_x_q;
    sum_l_d     = sum_l_q;
    sum_r_d     = sum_r_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    // Configuration writes; unknown indexes are dropped.
    if (cfg_fire) begin
      case (cfg_index_i)
        CFG_SILENCE_THRESHOLD: thr_d    = cfg_data_i[THRESH_W-1:0];
        CFG_SMOOTHING_WEIGHT:  weight_d = cfg_data_i[WEIGHT_W-1:0];
        default: begin
        end
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        step_d = STEP_LR;
        if (calc_start) begin
          fresh_d = 1'b0;
        end
      end
      ST_SAMPLE: begin
        case (step_q)
          STEP_OLR, STEP_LL:   sum_x_d = add_out;
          STEP_OLL, STEP_RR:   sum_l_d = add_out;
          STEP_ORR, STEP_DONE: sum_r_d = add_out;
          default: begin
          end
        endcase
        if (step_q == STEP_DONE) begin
          fresh_d = 1'b1;
          if (wptr_q == AW'(WINDOW_DEPTH - 1)) begin
            wptr_d = '0;
            full_d = 1'b1;
          end else begin
            wptr_d = wptr_q + 1'b1;
          end
        end else begin
          step_d = smp_step_e'(step_q + 3'd1);
        end
      end
      ST_SMOOTH_OUT: begin
        if (out_free) begin
          sm_d                       = sm_new;
          out_valid_d                = 1'b1;
          out_d.raw_correlation      = calc_res.raw;
          out_d.smoothed_correlation = sm_new;
          out_d.silent               = calc_res.silent;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state, window sums and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_LR;
      wptr_q      <= '0;
      full_q      <= 1'b0;
      fresh_q     <= 1'b0;
      sm_q        <= '0;
      thr_q       <= THRESH_RESET;
      weight_q    <= WEIGHT_RESET;
      sum_x_q     <= '0;
      sum_l_q     <= '0;
      sum_r_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      wptr_q      <= wptr_d;
      full_q      <= full_d;
      fresh_q     <= fresh_d;
      sm_q        <= sm_d;
      thr_q       <= thr_d;
      weight_q    <= weight_d;
      sum_x_q     <= sum_x_d;
      sum_l_q     <= sum_l_d;
      sum_r_q     <= sum_r_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    out_q  <= out_d;
    if (ram_re) begin
      smp_l_q <= in_item_i.left_sample;
      smp_r_q <= in_item_i.right_sample;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // A result appears only after the smoothing step.
  `ASSERT_DEFAULT(a_out_after_smooth, $rose(out_valid_o) |-> $past(state_q == ST_SMOOTH_OUT), "result out of sequence")
  // The correlation unit finishes only while the sequencer waits for it.
  `ASSERT_DEFAULT(a_calc_done_waited, calc_res.done |-> state_q == ST_CALC, "unexpected calc done")
  // A completed sample transfer marks the window as fresh.
  `ASSERT_DEFAULT(a_sample_fresh, (state_q == ST_SAMPLE && step_q == STEP_DONE) |=> fresh_q, "fresh not set")

endmodule
